// File: src/wmef_pkg.sv
// Shared types and constants for the window median and EWMA particulate filter.
package wmef_pkg;

  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned CH_W          = $clog2(NUM_CH);
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned FRAC_W        = 8;
  localparam int unsigned AVG_W         = SAMPLE_W + FRAC_W;
  localparam int unsigned WEIGHT_W      = 16;
  localparam int unsigned PROD_W        = WEIGHT_W + AVG_W;
  localparam int unsigned DEFAULT_DEPTH = 8;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd19661;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EW_MUL,
    ST_EW_ADD,
    ST_DONE
  } state_e;

endpackage

// File: src/window_median_ewma_filter.sv
// Top level of the three-channel sliding-window median filter with EWMA smoothing.
//
// Each accepted input transaction carries one PM1.0, PM2.5 and PM10 sample. The three
// samples are written together into one slot of a ring window of WINDOW_DEPTH entries,
// and for every channel the block picks the element of rank count/2 among the filled
// entries (the upper median when the count is even). That median, scaled to 16.8 fixed
// point, is folded into a per-channel exponential moving average whose weight is the
// Q0.16 register written through cfg_we_i/cfg_data_i; the very first sample after reset
// loads the averages directly. The median is found by rank counting: every filled entry
// is read once as a candidate and then compared against the whole window, one window
// word per cycle through the single RAM read port, with all three channels compared in
// parallel lanes. The averages are then updated one channel after another through one
// shared 16 x 24 multiplier and one adder-subtractor. An input transaction keeps
// in_stall_o high through the rank-count loop and the channel updates. The result sits
// in an output register, so the next input transaction is accepted while a finished
// result still waits for out_stall_i to drop. The smoothing weight is only to be
// written while the block is idle.
module window_median_ewma_filter #(
  parameter int unsigned WINDOW_DEPTH = wmef_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: smoothing weight, unsigned Q0.16.
  input  logic                              cfg_we_i,
  input  logic [wmef_pkg::WEIGHT_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wmef_pkg::SAMPLE_W-1:0]     sample_pm1_i,
  input  logic [wmef_pkg::SAMPLE_W-1:0]     sample_pm25_i,
  input  logic [wmef_pkg::SAMPLE_W-1:0]     sample_pm10_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wmef_pkg::AVG_W-1:0]        smooth_pm1_o,
  output logic [wmef_pkg::AVG_W-1:0]        smooth_pm25_o,
  output logic [wmef_pkg::AVG_W-1:0]        smooth_pm10_o
);

  localparam int unsigned NumCh = wmef_pkg::NUM_CH;
  localparam int unsigned SW    = wmef_pkg::SAMPLE_W;
  localparam int unsigned AW    = wmef_pkg::AVG_W;
  localparam int unsigned PW    = wmef_pkg::PROD_W;
  localparam int unsigned ChW   = wmef_pkg::CH_W;
  localparam int unsigned AddrW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned WordW = NumCh * SW;

  localparam logic [CntW-1:0]  DepthCnt = CntW'(WINDOW_DEPTH);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(WINDOW_DEPTH - 1);
  localparam logic [ChW-1:0]   LastCh   = ChW'(NumCh - 1);

  wmef_pkg::state_e state_q, state_d;

  logic [wmef_pkg::WEIGHT_W-1:0] weight_q;
  logic [AddrW-1:0]              wslot_q, wslot_d;
  logic [CntW-1:0]               fill_q, fill_d;
  logic                          primed_q, primed_d;
  logic [CntW-1:0]               cand_idx_q, cand_idx_d;
  logic [CntW-1:0]               scan_idx_q, scan_idx_d;
  logic [ChW-1:0]                ch_q, ch_d;
  logic                          out_valid_q, out_valid_d;

  // Datapath registers; all but avg_q have no reset.
  logic [SW-1:0]   cand_q  [NumCh];
  logic [SW-1:0]   cand_d  [NumCh];
  logic [CntW-1:0] below_q [NumCh];
  logic [CntW-1:0] below_d [NumCh];
  logic [CntW-1:0] same_q  [NumCh];
  logic [CntW-1:0] same_d  [NumCh];
  logic [SW-1:0]   med_q   [NumCh];
  logic [SW-1:0]   med_d   [NumCh];
  logic [AW-1:0]   avg_q   [NumCh];
  logic [AW-1:0]   avg_d   [NumCh];
  logic [AW-1:0]   out_q   [NumCh];
  logic [AW-1:0]   out_d   [NumCh];
  logic [PW-1:0]   prod_q, prod_d;
  logic            neg_q, neg_d;

  logic             in_accept;
  logic             ram_we;
  logic [WordW-1:0] ram_wdata;
  logic [WordW-1:0] ram_rdata;
  logic [CntW-1:0]  rd_idx;
  logic [CntW-1:0]  rank;
  logic [AW-1:0]    target;
  logic [AW-1:0]    cur_avg;
  logic [AW-1:0]    diff;
  logic [PW-1:0]    prod_round;
  logic [AW-1:0]    step;

  assign in_accept = in_valid_i && !in_stall_o;
  assign ram_we    = in_accept;
  assign ram_wdata = {sample_pm10_i, sample_pm25_i, sample_pm1_i};
  assign rank      = fill_q >> 1;

  // The shared update datapath works on the channel selected by ch_q.
  assign target     = {med_q[ch_q], {wmef_pkg::FRAC_W{1'b0}}};
  assign cur_avg    = avg_q[ch_q];
  assign diff       = (target < cur_avg) ? (cur_avg - target) : (target - cur_avg);
  assign prod_round = prod_q + PW'(16'hFFFF);
  assign step       = neg_q ? prod_round[PW-1:16] : prod_q[PW-1:16];

  wmef_ram #(
    .WIDTH (WordW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wslot_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmef_pkg::ST_IDLE;
      weight_q    <= wmef_pkg::WEIGHT_RESET;
      wslot_q     <= '0;
      fill_q      <= '0;
      primed_q    <= 1'b0;
      cand_idx_q  <= '0;
      scan_idx_q  <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        avg_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      wslot_q     <= wslot_d;
      fill_q      <= fill_d;
      primed_q    <= primed_d;
      cand_idx_q  <= cand_idx_d;
      scan_idx_q  <= scan_idx_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      avg_q       <= avg_d;
      if (cfg_we_i) begin
        weight_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    below_q <= below_d;
    same_q  <= same_d;
    med_q   <= med_d;
    out_q   <= out_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
  end

  always_comb begin
    state_d     = state_q;
    wslot_d     = wslot_q;
    fill_d      = fill_q;
    primed_d    = primed_q;
    cand_idx_d  = cand_idx_q;
    scan_idx_d  = scan_idx_q;
    ch_d        = ch_q;
    cand_d      = cand_q;
    below_d     = below_q;
    same_d      = same_q;
    med_d       = med_q;
    avg_d       = avg_q;
    out_d       = out_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    rd_idx      = scan_idx_q;
    in_stall_o  = 1'b1;
    // A waiting result leaves once the receiver stops stalling.
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      wmef_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          wslot_d = (wslot_q == LastSlot) ? '0 : wslot_q + AddrW'(1);
          if (fill_q != DepthCnt) begin
            fill_d = fill_q + CntW'(1);
          end
          state_d = wmef_pkg::ST_CAND;
        end
      end

      wmef_pkg::ST_CAND: begin
        rd_idx     = '0;
        cand_idx_d = '0;
        state_d    = wmef_pkg::ST_LOAD;
      end

      // The candidate word is on the read port; start the window scan at entry 0.
      wmef_pkg::ST_LOAD: begin
        for (int c = 0; c < NumCh; c++) begin
          cand_d[c]  = ram_rdata[c*SW +: SW];
          below_d[c] = '0;
          same_d[c]  = '0;
        end
        rd_idx     = '0;
        scan_idx_d = CntW'(1);
        state_d    = wmef_pkg::ST_SCAN;
      end

      // The read port shows entry scan_idx_q-1 while entry scan_idx_q is addressed.
      wmef_pkg::ST_SCAN: begin
        for (int c = 0; c < NumCh; c++) begin
          below_d[c] = below_q[c] + CntW'(ram_rdata[c*SW +: SW] < cand_q[c]);
          same_d[c]  = same_q[c] + CntW'(ram_rdata[c*SW +: SW] == cand_q[c]);
        end
        rd_idx = scan_idx_q;
        if (scan_idx_q == fill_q) begin
          state_d = wmef_pkg::ST_DECIDE;
        end else begin
          scan_idx_d = scan_idx_q + CntW'(1);
        end
      end

      // Any candidate that holds the wanted rank carries the median value.
      wmef_pkg::ST_DECIDE: begin
        for (int c = 0; c < NumCh; c++) begin
          if ((below_q[c] <= rank) &&
              ({1'b0, rank} < ({1'b0, below_q[c]} + {1'b0, same_q[c]}))) begin
            med_d[c] = cand_q[c];
          end
        end
        rd_idx     = cand_idx_q + CntW'(1);
        cand_idx_d = cand_idx_q + CntW'(1);
        if (cand_idx_q + CntW'(1) == fill_q) begin
          ch_d    = '0;
          state_d = wmef_pkg::ST_EW_MUL;
        end else begin
          state_d = wmef_pkg::ST_LOAD;
        end
      end

      wmef_pkg::ST_EW_MUL: begin
        neg_d   = target < cur_avg;
        prod_d  = PW'(weight_q) * PW'(diff);
        state_d = wmef_pkg::ST_EW_ADD;
      end

      // A falling step rounds its magnitude up, which floors the signed step.
      wmef_pkg::ST_EW_ADD: begin
        if (!primed_q) begin
          avg_d[ch_q] = target;
        end else if (neg_q) begin
          avg_d[ch_q] = cur_avg - step;
        end else begin
          avg_d[ch_q] = cur_avg + step;
        end
        if (ch_q == LastCh) begin
          state_d = wmef_pkg::ST_DONE;
        end else begin
          ch_d    = ch_q + ChW'(1);
          state_d = wmef_pkg::ST_EW_MUL;
        end
      end

      wmef_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = avg_q;
          out_valid_d = 1'b1;
          primed_d    = 1'b1;
          state_d     = wmef_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wmef_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign smooth_pm1_o  = out_q[0];
  assign smooth_pm25_o = out_q[1];
  assign smooth_pm10_o = out_q[2];

endmodule

// File: src/wmef_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wmef_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wmef_checker.sv
// Port-level checker for the window median filter, bound to the top level.
module wmef_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [wmef_pkg::AVG_W-1:0]    smooth_pm1_o,
  input logic [wmef_pkg::AVG_W-1:0]    smooth_pm25_o,
  input logic [wmef_pkg::AVG_W-1:0]    smooth_pm10_o
);

  // An accepted sample keeps the input side busy afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o)
    else $error("input side not busy after an accepted transaction");

  // The input side frees up only when a fresh result is presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input side freed without a result");

  // A result valid rises only as the block turns idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while the block is still busy");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(smooth_pm1_o) && $stable(smooth_pm25_o) &&
       $stable(smooth_pm10_o)))
    else $error("stalled result changed");

endmodule

bind window_median_ewma_filter wmef_checker u_wmef_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .smooth_pm1_o  (smooth_pm1_o),
  .smooth_pm25_o (smooth_pm25_o),
  .smooth_pm10_o (smooth_pm10_o)
);

// File: tb/testbench.sv
// Self-checking testbench for the window median and EWMA particulate filter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wmef_pkg::*;

  // One set of three channel values, indexed 0 = PM1.0, 1 = PM2.5, 2 = PM10.
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_set_t;
  typedef logic [NUM_CH-1:0][AVG_W-1:0]    smooth_set_t;

  localparam int unsigned MAX_GAP      = 19;
  localparam int unsigned REPORT_LIMIT = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WEIGHT_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [SAMPLE_W-1:0] sample_pm1_i;
  logic [SAMPLE_W-1:0] sample_pm25_i;
  logic [SAMPLE_W-1:0] sample_pm10_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [AVG_W-1:0]  smooth_pm1_o;
  logic [AVG_W-1:0]  smooth_pm25_o;
  logic [AVG_W-1:0]  smooth_pm10_o;

  window_median_ewma_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_pm1_i  (sample_pm1_i),
    .sample_pm25_i (sample_pm25_i),
    .sample_pm10_i (sample_pm10_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .smooth_pm1_o  (smooth_pm1_o),
    .smooth_pm25_o (smooth_pm25_o),
    .smooth_pm10_o (smooth_pm10_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the filter state. It advances once per accepted input
  // transaction, so it always describes the block as the next sample will see it.
  logic [SAMPLE_W-1:0] pm_window [NUM_CH][DEFAULT_DEPTH];
  int unsigned         next_slot    = 0;
  int unsigned         filled_count = 0;
  bit                  avg_primed   = 1'b0;
  logic [AVG_W-1:0]    pm_avg [NUM_CH];
  logic [WEIGHT_W-1:0] weight_model = WEIGHT_RESET;

  // Smoothed values that the block still owes, oldest first.
  smooth_set_t expected_smooth_q [$];

  int unsigned error_count     = 0;
  int unsigned samples_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned weights_used    = 1;

  // Pacing controls shared by the stimulus and the result receiver.
  bit          sender_quiet   = 1'b0;
  bit          receiver_quiet = 1'b0;
  bit          hold_request   = 1'b0;
  bit          hold_active    = 1'b0;
  int unsigned hold_cycles    = 0;

  string ch_name [NUM_CH] = '{"smooth_pm1", "smooth_pm25", "smooth_pm10"};

  // Rank-count median: the entry of rank count/2 among the filled slots. Ties are
  // handled by counting equal entries, so the upper median falls out for even counts.
  function automatic logic [SAMPLE_W-1:0] rank_median(int unsigned ch);
    int unsigned rank;
    int unsigned below;
    int unsigned same;
    rank = filled_count / 2;
    for (int unsigned i = 0; i < filled_count; i++) begin
      below = 0;
      same  = 0;
      for (int unsigned j = 0; j < filled_count; j++) begin
        if (pm_window[ch][j] < pm_window[ch][i]) begin
          below++;
        end else if (pm_window[ch][j] == pm_window[ch][i]) begin
          same++;
        end
      end
      if (below <= rank && rank < below + same) begin
        return pm_window[ch][i];
      end
    end
    return '0;
  endfunction

  // One EWMA step in 16.8. The signed shift floors the correction, so a falling
  // median pulls the average down by the rounded-up magnitude.
  function automatic logic [AVG_W-1:0] ewma_step(logic [AVG_W-1:0] avg,
                                                 logic [AVG_W-1:0] target);
    longint diff;
    longint prod;
    diff = longint'(target) - longint'(avg);
    prod = longint'(weight_model) * diff;
    return AVG_W'(longint'(avg) + (prod >>> 16));
  endfunction

  function automatic smooth_set_t predict_smooth(sample_set_t samples);
    smooth_set_t result;
    logic [AVG_W-1:0] target;
    for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
      pm_window[ch][next_slot] = samples[ch];
    end
    next_slot = (next_slot + 1) % DEFAULT_DEPTH;
    if (filled_count < DEFAULT_DEPTH) begin
      filled_count++;
    end
    for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
      target = {rank_median(ch), {FRAC_W{1'b0}}};
      pm_avg[ch] = avg_primed ? ewma_step(pm_avg[ch], target) : target;
      result[ch] = pm_avg[ch];
    end
    avg_primed = 1'b1;
    return result;
  endfunction

  // Offers one sample transaction after a gap, random unless sender_quiet is set,
  // and records its expected result at the clock edge where the block takes it. Valid
  // stays high across back-to-back transactions, never dropped and raised in one step.
  task automatic send_sample(logic [SAMPLE_W-1:0] pm1, logic [SAMPLE_W-1:0] pm25,
                             logic [SAMPLE_W-1:0] pm10);
    int unsigned gap;
    sample_set_t samples;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
    samples[0] = pm1;
    samples[1] = pm25;
    samples[2] = pm10;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_pm1_i  <= pm1;
    sample_pm25_i <= pm25;
    sample_pm10_i <= pm10;
    do @(posedge clk_i); while (in_stall_o);
    expected_smooth_q.push_back(predict_smooth(samples));
    samples_sent++;
  endtask

  // Stops offering input and waits until every owed result has been taken and the
  // block no longer stalls its input, which leaves it idle for a register write.
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_smooth_q.size() != 0 || in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_weight(logic [WEIGHT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    weight_model = value;
    weights_used++;
  endtask

  // Draws one channel sample. Besides the full range, the mix favors narrow bands
  // and tiny values so windows often hold ties, plus the two range extremes.
  function automatic logic [SAMPLE_W-1:0] draw_sample(int unsigned mode,
                                                      logic [SAMPLE_W-1:0] base);
    case (mode)
      5, 6:    return base + SAMPLE_W'($urandom_range(0, 7));
      7:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      8, 9:    return SAMPLE_W'($urandom_range(0, 7));
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // The first samples after reset: the priming load, every fill level of the
  // window from one to eight entries (odd and even counts), and the ring wrap.
  task automatic test_window_fill();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    send_sample(16'h0000, 16'hFFFF, 16'h8000);
    send_sample(16'hFFFF, 16'h0000, 16'h0001);
    send_sample(16'h5555, 16'hAAAA, 16'h8000);
    send_sample(16'h0001, 16'h0001, 16'h7FFF);
    send_sample(16'hFFFF, 16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h8000);
    send_sample(16'hAAAA, 16'h5555, 16'h8000);
    send_sample(16'h0001, 16'h0001, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF, 16'h0000);
    send_sample(16'h1234, 16'hFEDC, 16'h8000);
    wait_results_drained();
  endtask

  // Weight extremes: full weight tracks the median almost at once, the smallest
  // weight barely moves, and a zero weight freezes the averages.
  task automatic test_weight_extremes();
    write_weight(16'hFFFF);
    repeat (3) send_sample(16'h0000, 16'h0000, 16'h0000);
    wait_results_drained();
    write_weight(16'h0001);
    repeat (3) send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_results_drained();
    write_weight(16'h0000);
    send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_results_drained();
  endtask

  // Long random runs under several weights. Pacing on both sides is redrawn every
  // 25 transactions so busy and fully streaming stretches alternate.
  task automatic test_random_traffic();
    logic [WEIGHT_W-1:0] weight;
    logic [SAMPLE_W-1:0] base [NUM_CH];
    int unsigned mode;
    for (int unsigned phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       weight = 16'hFFFF;
        1:       weight = 16'h0001;
        3:       weight = WEIGHT_RESET;
        5:       weight = 16'h8000;
        default: weight = WEIGHT_W'($urandom_range(1, 65535));
      endcase
      write_weight(weight);
      for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
        base[ch] = SAMPLE_W'($urandom_range(0, 65535));
      end
      for (int unsigned n = 0; n < 100; n++) begin
        if (n % 25 == 0) begin
          sender_quiet   = ($urandom_range(0, 3) == 0);
          receiver_quiet = ($urandom_range(0, 3) == 0);
        end
        mode = $urandom_range(0, 9);
        send_sample(draw_sample(mode, base[0]), draw_sample(mode, base[1]),
                    draw_sample(mode, base[2]));
      end
      wait_results_drained();
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  // The receiver holds off far longer than two computations take while the sender
  // streams, so the output register fills and the block must stall its input.
  task automatic test_output_backpressure();
    hold_cycles  = 400;
    hold_request = 1'b1;
    wait (hold_active);
    sender_quiet = 1'b1;
    repeat (12) begin
      send_sample(SAMPLE_W'($urandom_range(0, 65535)), SAMPLE_W'($urandom_range(0, 65535)),
                  SAMPLE_W'($urandom_range(0, 65535)));
    end
    sender_quiet = 1'b0;
    wait_results_drained();
  endtask

  // Result receiver: stalls for a random number of cycles before each result, or
  // for a long stretch when the backpressure test asks for it.
  initial begin : result_receiver
    int unsigned gap;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        hold_active = 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_request = 1'b0;
        hold_active  = 1'b0;
      end
      gap = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && !hold_request);
    end
  end

  // Result checker: every output transaction is compared field by field with the
  // oldest expectation.
  always @(posedge clk_i) begin : smooth_checker
    smooth_set_t want;
    smooth_set_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got[0] = smooth_pm1_o;
      got[1] = smooth_pm25_o;
      got[2] = smooth_pm10_o;
      if (expected_smooth_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected result transaction, got 0x%06h 0x%06h 0x%06h",
                   $time, got[0], got[1], got[2]);
        end
      end else begin
        want = expected_smooth_q.pop_front();
        results_checked++;
        for (int unsigned ch = 0; ch < NUM_CH; ch++) begin
          if (got[ch] !== want[ch]) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: %s mismatch, expected 0x%06h, actual 0x%06h",
                       $time, ch_name[ch], want[ch], got[ch]);
            end
          end
        end
      end
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    sample_pm1_i  = '0;
    sample_pm25_i = '0;
    sample_pm10_i = '0;
    rst_ni        = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_window_fill();
    test_weight_extremes();
    test_random_traffic();
    test_output_backpressure();

    wait_results_drained();
    repeat (100) @(posedge clk_i);
    if (expected_smooth_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_smooth_q.size());
    end

    $display("Ran %0d samples through window fill, ring wrap and %0d weight settings,",
             samples_sent, weights_used);
    $display("including zero and full weight and a stalled output; %0d results checked.",
             results_checked);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of sample computations plus the long
  // output hold.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
